// ===== rtl/core/i2cbm_pkg.sv =====
package i2cbm_pkg;

    // Field widths of the request and result channels.
    localparam int FUNC_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int TICK_W     = 10;
    localparam int PULSE_W    = 4;
    localparam int BITCNT_W   = 4;
    localparam int PHASE_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Command codes carried in func.
    localparam logic [FUNC_W-1:0] CMD_NONE    = 3'd0;
    localparam logic [FUNC_W-1:0] CMD_START   = 3'd1;
    localparam logic [FUNC_W-1:0] CMD_STOP    = 3'd2;
    localparam logic [FUNC_W-1:0] CMD_WRITE   = 3'd3;
    localparam logic [FUNC_W-1:0] CMD_READ    = 3'd4;
    localparam logic [FUNC_W-1:0] CMD_RECOVER = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LIMIT = 2'd1;

    // Configuration reset values.
    localparam logic [TICK_W-1:0]  HALF_PERIOD_RESET = 10'd5;
    localparam logic [PULSE_W-1:0] PULSE_LIMIT_RESET = 4'd10;

    // Bits in one byte transfer.
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

    // Sequencer phases.
    localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START_A    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_START_B    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_START_C    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_STOP_A     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_STOP_B     = 4'd5;
    localparam logic [PHASE_W-1:0] PH_STOP_C     = 4'd6;
    localparam logic [PHASE_W-1:0] PH_BIT_LOW    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_BIT_HIGH   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_ACK_LOW    = 4'd9;
    localparam logic [PHASE_W-1:0] PH_ACK_HIGH   = 4'd10;
    localparam logic [PHASE_W-1:0] PH_PULSE_LOW  = 4'd11;
    localparam logic [PHASE_W-1:0] PH_PULSE_HIGH = 4'd12;

    // One input request.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic              sda_in;
    } item_t;

    // One result.
    typedef struct packed {
        logic              scl;
        logic              sda_drive;
        logic              sda_level;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rx_byte;
        logic              acked;
        logic              bus_freed;
        logic              rejected;
    } result_t;

    // Bus line levels shown during one step.
    typedef struct packed {
        logic scl;
        logic sda_drive;
        logic sda_level;
    } lines_t;

endpackage

// ===== rtl/core/i2c_bit_level_master_core.sv =====
// Channel   Direction  Handshake              Payload
// in        request    in_valid / in_ready    func, tx_byte, send_ack, sda_in
// out       result     out_valid / out_ready  scl, sda_drive, sda_level, busy_res,
//                                             done_res, rx_byte, acked, bus_freed,
//                                             rejected
// cfg       write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each request is one bus tick. The block takes one request per clock cycle while
// the result channel is not stalled. An accepted request is held in the input
// register, and one pass through the phase sequencer loads its result into the
// result register.
// The sequencer state advances only when the request in the input register moves
// into the result register, so a stalled result channel holds everything in place.
// Reset (rst_n low, asynchronous) empties both registers, puts the sequencer in
// its idle phase with SCL high and SDA released, and loads the configuration
// reset values. Configuration writes are taken in every cycle.
module i2c_bit_level_master_core
    import i2cbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [FUNC_W-1:0]     func,
    input  logic [BYTE_W-1:0]     tx_byte,
    input  logic                  send_ack,
    input  logic                  sda_in,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  scl,
    output logic                  sda_drive,
    output logic                  sda_level,
    output logic                  busy_res,
    output logic                  done_res,
    output logic [BYTE_W-1:0]     rx_byte,
    output logic                  acked,
    output logic                  bus_freed,
    output logic                  rejected,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                in_valid_reg;
    item_t               in_item_reg;
    logic                out_valid_reg;
    result_t             res_reg;
    result_t             step_res;
    logic                step_fire;
    logic                in_fire;
    logic [TICK_W-1:0]   half_period_reg;
    logic [PULSE_W-1:0]  pulse_limit_reg;

    // A request moves on when the result register is empty or being drained.
    assign step_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || step_fire;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers. Writes to indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            pulse_limit_reg <= PULSE_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_HALF_PERIOD)
                half_period_reg <= cfg_data[TICK_W-1:0];
            else if (cfg_index == REG_PULSE_LIMIT)
                pulse_limit_reg <= cfg_data[PULSE_W-1:0];
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_fire)
            in_valid_reg <= 1'b1;
        else if (step_fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_item_reg <= '{func: func, tx_byte: tx_byte, send_ack: send_ack,
                             sda_in: sda_in};
    end

    // The sequencer computes the whole tick in one pass and keeps the bus state.
    i2cbm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_fire),
        .item        (in_item_reg),
        .half_period (half_period_reg),
        .pulse_limit (pulse_limit_reg),
        .res         (step_res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
            res_reg <= step_res;
    end

    assign out_valid = out_valid_reg;
    assign scl       = res_reg.scl;
    assign sda_drive = res_reg.sda_drive;
    assign sda_level = res_reg.sda_level;
    assign busy_res  = res_reg.busy;
    assign done_res  = res_reg.done;
    assign rx_byte   = res_reg.rx_byte;
    assign acked     = res_reg.acked;
    assign bus_freed = res_reg.bus_freed;
    assign rejected  = res_reg.rejected;

endmodule

// ===== rtl/core/i2cbm_seq.sv =====
module i2cbm_seq
    import i2cbm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  item_t               item,
    input  logic [TICK_W-1:0]   half_period,
    input  logic [PULSE_W-1:0]  pulse_limit,
    output result_t             res
);

    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [FUNC_W-1:0]   cmd_reg, cmd_next;
    logic [BITCNT_W-1:0] bit_reg, bit_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [PULSE_W-1:0]  pulse_reg, pulse_next;
    logic                ack_reg, ack_next;
    lines_t              lines_reg, lines_next;

    logic                enter_en;
    logic [PHASE_W-1:0]  enter_ph;
    logic                finish;
    logic                rej;
    logic [TICK_W-1:0]   hp;
    logic [PULSE_W-1:0]  lim;
    logic [BITCNT_W-1:0] bit_inc;
    logic [PULSE_W-1:0]  pulse_inc;

    // Line levels shown on entry to a step. The bit, acknowledge and pulse SCL-high steps keep SDA as it is.
    function automatic lines_t step_lines(input logic [PHASE_W-1:0] p,
                                          input logic [FUNC_W-1:0]  cmd,
                                          input logic               msb,
                                          input logic               ackf,
                                          input lines_t             cur);
        lines_t l;
        l = '{scl: 1'b1, sda_drive: cur.sda_drive, sda_level: cur.sda_level};
        unique case (p)
            PH_START_A: l = '{scl: 1'b1, sda_drive: 1'b1, sda_level: 1'b1};
            PH_START_B: l = '{scl: 1'b1, sda_drive: 1'b1, sda_level: 1'b0};
            PH_START_C: l = '{scl: 1'b0, sda_drive: 1'b1, sda_level: 1'b0};
            PH_STOP_A:  l = '{scl: 1'b0, sda_drive: 1'b1, sda_level: 1'b0};
            PH_STOP_B:  l = '{scl: 1'b1, sda_drive: 1'b1, sda_level: 1'b0};
            PH_STOP_C:  l = '{scl: 1'b1, sda_drive: 1'b1, sda_level: 1'b1};
            PH_BIT_LOW:
            begin
                if (cmd == CMD_WRITE)
                    l = '{scl: 1'b0, sda_drive: 1'b1, sda_level: msb};
                else
                    l = '{scl: 1'b0, sda_drive: 1'b0, sda_level: 1'b1};
            end
            PH_ACK_LOW:
            begin
                if (cmd == CMD_READ)
                    l = '{scl: 1'b0, sda_drive: 1'b1, sda_level: ~ackf};
                else
                    l = '{scl: 1'b0, sda_drive: 1'b0, sda_level: 1'b1};
            end
            PH_PULSE_LOW: l = '{scl: 1'b0, sda_drive: 1'b0, sda_level: 1'b1};
            default:      l = '{scl: 1'b1, sda_drive: cur.sda_drive,
                                sda_level: cur.sda_level};
        endcase
        return l;
    endfunction

    assign hp        = (half_period == '0) ? TICK_W'(1) : half_period;
    assign lim       = (pulse_limit == '0) ? PULSE_W'(1) : pulse_limit;
    assign bit_inc   = bit_reg + BITCNT_W'(1);
    assign pulse_inc = pulse_reg + PULSE_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        tick_next  = tick_reg;
        pulse_next = pulse_reg;
        ack_next   = ack_reg;
        lines_next = lines_reg;
        enter_en   = 1'b0;
        enter_ph   = PH_IDLE;
        finish     = 1'b0;
        rej        = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (item.func >= CMD_START && item.func <= CMD_RECOVER)
            begin
                cmd_next   = item.func;
                bit_next   = '0;
                pulse_next = '0;
                enter_en   = 1'b1;
                unique case (item.func) inside
                    CMD_START, CMD_RECOVER:
                    begin
                        ack_next = 1'b0;
                        enter_ph = PH_START_A;
                    end
                    CMD_STOP:
                        enter_ph = PH_STOP_A;
                    CMD_WRITE:
                    begin
                        shift_next = item.tx_byte;
                        enter_ph   = PH_BIT_LOW;
                    end
                    default:
                    begin
                        shift_next = '0;
                        ack_next   = item.send_ack;
                        enter_ph   = PH_BIT_LOW;
                    end
                endcase
            end
        end
        else
        begin
            rej = (item.func != CMD_NONE);
            if (tick_reg < hp)
            begin
                tick_next = tick_reg + TICK_W'(1);
            end
            else
            begin
                unique case (phase_reg)
                    PH_START_A:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_START_B;
                    end
                    PH_START_B:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_START_C;
                    end
                    PH_START_C:
                    begin
                        if (cmd_reg == CMD_RECOVER)
                        begin
                            enter_en = 1'b1;
                            enter_ph = PH_STOP_A;
                        end
                        else
                            finish = 1'b1;
                    end
                    PH_STOP_A:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_STOP_B;
                    end
                    PH_STOP_B:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_STOP_C;
                    end
                    PH_STOP_C:
                    begin
                        if (cmd_reg == CMD_RECOVER && bit_reg == '0)
                        begin
                            pulse_next = '0;
                            enter_en   = 1'b1;
                            enter_ph   = PH_PULSE_LOW;
                        end
                        else
                            finish = 1'b1;
                    end
                    PH_BIT_LOW:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_BIT_HIGH;
                    end
                    PH_BIT_HIGH:
                    begin
                        shift_next = {shift_reg[BYTE_W-2:0],
                                      (cmd_reg == CMD_READ) & item.sda_in};
                        bit_next   = bit_inc;
                        enter_en   = 1'b1;
                        enter_ph   = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_BIT_LOW;
                    end
                    PH_ACK_LOW:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH:
                    begin
                        if (cmd_reg == CMD_WRITE)
                            ack_next = ~item.sda_in;
                        finish = 1'b1;
                    end
                    PH_PULSE_LOW:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_PULSE_HIGH;
                    end
                    PH_PULSE_HIGH:
                    begin
                        enter_en = 1'b1;
                        if (item.sda_in)
                        begin
                            ack_next = 1'b1;
                            bit_next = BITCNT_W'(1);
                            enter_ph = PH_STOP_A;
                        end
                        else
                        begin
                            pulse_next = pulse_inc;
                            if (pulse_inc >= lim)
                            begin
                                ack_next = 1'b0;
                                bit_next = BITCNT_W'(1);
                                enter_ph = PH_STOP_A;
                            end
                            else
                                enter_ph = PH_PULSE_LOW;
                        end
                    end
                    default:
                        finish = 1'b1;
                endcase
            end
        end

        if (enter_en)
        begin
            phase_next = enter_ph;
            tick_next  = TICK_W'(1);
            lines_next = step_lines(enter_ph, cmd_next, shift_next[BYTE_W-1], ack_next,
                                    lines_reg);
        end

        if (finish)
        begin
            phase_next = PH_IDLE;
            tick_next  = '0;
            if (cmd_reg == CMD_WRITE || cmd_reg == CMD_READ)
                lines_next = '{scl: 1'b0, sda_drive: 1'b0, sda_level: 1'b1};
        end
    end

    always_comb
    begin
        res.scl       = lines_next.scl;
        res.sda_drive = lines_next.sda_drive;
        res.sda_level = lines_next.sda_level;
        res.busy      = (phase_next != PH_IDLE);
        res.done      = finish;
        res.rx_byte   = (finish && cmd_reg == CMD_READ) ? shift_next : '0;
        res.acked     = finish && (cmd_reg == CMD_WRITE) && ack_next;
        res.bus_freed = finish && (cmd_reg == CMD_RECOVER) && ack_next;
        res.rejected  = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= CMD_NONE;
            bit_reg   <= '0;
            shift_reg <= '0;
            tick_reg  <= '0;
            pulse_reg <= '0;
            ack_reg   <= 1'b0;
            lines_reg <= '{scl: 1'b1, sda_drive: 1'b0, sda_level: 1'b1};
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            tick_reg  <= tick_next;
            pulse_reg <= pulse_next;
            ack_reg   <= ack_next;
            lines_reg <= lines_next;
        end
    end

endmodule

// ===== rtl/core/i2cbm_checker.sv =====
module i2cbm_checker
    import i2cbm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  scl,
    input logic                  sda_drive,
    input logic                  sda_level,
    input logic                  busy_res,
    input logic                  done_res,
    input logic [BYTE_W-1:0]     rx_byte,
    input logic                  acked,
    input logic                  bus_freed
);

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rx_byte) && $stable(scl)
            && $stable(done_res) && $stable(busy_res))
        else $error("result changed while stalled");

    // Requests are only held off while a result waits on the output side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back pressure");

    // A finishing command leaves the sequencer idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done shown while still busy");

    // Result fields are zero except on a finishing tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> rx_byte == '0 && !acked && !bus_freed)
        else $error("result field set without done");

    // A released SDA line reads as high.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sda_drive |-> sda_level)
        else $error("SDA level low while released");

endmodule

bind i2c_bit_level_master_core i2cbm_checker u_checker (.*);
